@@ hw/rtl/bottom_up_merge_sort_assert.svh @@
// Assertion macros for the merge sorter checker.
`ifndef BOTTOM_UP_MERGE_SORT_ASSERT_SVH
`define BOTTOM_UP_MERGE_SORT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define BUMS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BUMS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bums_pkg.sv @@
// Package for the merge sorter: payload types and defaults.
package bums_pkg;

  localparam int MaxElementsDef = 64;
  localparam int KeyWidthDef    = 32;
  localparam int MergeMinSize   = 1;

  typedef struct packed {
    logic [31:0] key;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [31:0] sorted_key;
    logic        last_out;
    logic        overflow;
  } out_t;

endpackage

@@ hw/rtl/bottom_up_merge_sort.sv @@
// Top level of the bottom-up merge sorter with ping-pong key banks.
//
//   channel   | signals                         | direction
//   ----------+---------------------------------+----------
//   input     | start_i, busy_o, in_i           | in
//   result    | result_valid_o, result_o        | out
//   config    | cfg_we_i, cfg_wdata_i           | in
//
// Load: one key per cycle while busy_o is low; a key with last starts the sort.
// Each merge pass over n keys steps ST_SETUP per run pair, then ST_RD and ST_CMP
// per key, as the source bank's read data is registered; ceil(log2 n) passes.
// Emit steps ST_EMR and ST_EMO per key, strobed on result_valid_o; no back-pressure.
// Reset clears the control state only; the banks need no clearing pass.
module bottom_up_merge_sort import bums_pkg::*; #(
  parameter int MAX_ELEMENTS = MaxElementsDef,
  parameter int KEY_WIDTH    = KeyWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  in_t  in_i,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  output logic result_valid_o,
  output out_t result_o
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  logic                 a_we, b_we;
  logic [AW-1:0]        a_waddr, b_waddr, raddr0, raddr1;
  logic [KEY_WIDTH-1:0] a_wdata, b_wdata;
  logic [KEY_WIDTH-1:0] a_rdata0, a_rdata1, b_rdata0, b_rdata1;

  bums_ctrl #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .in_i          (in_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .a_we_o        (a_we),
    .a_waddr_o     (a_waddr),
    .a_wdata_o     (a_wdata),
    .a_rdata0_i    (a_rdata0),
    .a_rdata1_i    (a_rdata1),
    .b_we_o        (b_we),
    .b_waddr_o     (b_waddr),
    .b_wdata_o     (b_wdata),
    .b_rdata0_i    (b_rdata0),
    .b_rdata1_i    (b_rdata1),
    .raddr0_o      (raddr0),
    .raddr1_o      (raddr1)
  );

  bums_bank #(
    .DEPTH(MAX_ELEMENTS),
    .WIDTH(KEY_WIDTH)
  ) u_bank_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .raddr0_i(raddr0),
    .raddr1_i(raddr1),
    .rdata0_o(a_rdata0),
    .rdata1_o(a_rdata1)
  );

  bums_bank #(
    .DEPTH(MAX_ELEMENTS),
    .WIDTH(KEY_WIDTH)
  ) u_bank_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .raddr0_i(raddr0),
    .raddr1_i(raddr1),
    .rdata0_o(b_rdata0),
    .rdata1_o(b_rdata1)
  );

endmodule

@@ hw/rtl/bums_bank.sv @@
// One key memory: one write port, two read ports, registered read data.
module bums_bank #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr0_i,
  input  logic [AW-1:0]    raddr1_i,
  output logic [WIDTH-1:0] rdata0_o,
  output logic [WIDTH-1:0] rdata1_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata0_o <= mem[raddr0_i];
    rdata1_o <= mem[raddr1_i];
  end

endmodule

@@ hw/rtl/bums_ctrl.sv @@
// Sequencer for load, merge passes and emit of the merge sorter.
module bums_ctrl import bums_pkg::*; #(
  parameter int MAX_ELEMENTS = MaxElementsDef,
  parameter int KEY_WIDTH    = KeyWidthDef,
  localparam int AW          = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  in_t                  in_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  output logic                 result_valid_o,
  output out_t                 result_o,
  // bank A
  output logic                 a_we_o,
  output logic [AW-1:0]        a_waddr_o,
  output logic [KEY_WIDTH-1:0] a_wdata_o,
  input  logic [KEY_WIDTH-1:0] a_rdata0_i,
  input  logic [KEY_WIDTH-1:0] a_rdata1_i,
  // bank B
  output logic                 b_we_o,
  output logic [AW-1:0]        b_waddr_o,
  output logic [KEY_WIDTH-1:0] b_wdata_o,
  input  logic [KEY_WIDTH-1:0] b_rdata0_i,
  input  logic [KEY_WIDTH-1:0] b_rdata1_i,
  // shared read addresses
  output logic [AW-1:0]        raddr0_o,
  output logic [AW-1:0]        raddr1_o
);

  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int IW = CW + 2;           // holds lo + 2*run width
  localparam int EW = KEY_WIDTH + 32;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PASS  = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_CMP   = 3'd4;
  localparam logic [2:0] ST_EMR   = 3'd5;
  localparam logic [2:0] ST_EMO   = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic          scmp_q;
  logic          src_q, src_d;
  logic [IW-1:0] rw_q, rw_d;
  logic [IW-1:0] lo_q, lo_d;
  logic [IW-1:0] mid_q, mid_d;
  logic [IW-1:0] hi_q, hi_d;
  logic [IW-1:0] i_q, i_d;
  logic [IW-1:0] j_q, j_d;
  logic [IW-1:0] d_q, d_d;
  logic          res_valid_q;
  out_t          res_q, res_d;

  logic                 accept;
  logic                 store_key;
  logic [IW-1:0]        n_ext;
  logic [IW-1:0]        mid_c, hi_c;
  logic [KEY_WIDTH-1:0] key_k;
  logic [EW-1:0]        key_ext, out_ext;
  logic [KEY_WIDTH-1:0] rd_l, rd_r, sign_flip, merged;
  logic                 less, take_l;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign store_key = accept && (cnt_q < CW'(MAX_ELEMENTS));
  assign busy_o    = (state_q != ST_IDLE);
  assign n_ext     = IW'(cnt_q);

  assign key_ext = EW'(in_i.key);
  assign key_k   = key_ext[KEY_WIDTH-1:0];

  assign rd_l = src_q ? b_rdata0_i : a_rdata0_i;
  assign rd_r = src_q ? b_rdata1_i : a_rdata1_i;

  // two's complement order = unsigned order with the sign bit flipped
  assign sign_flip = KEY_WIDTH'(scmp_q) << (KEY_WIDTH - 1);
  assign less      = (rd_l ^ sign_flip) < (rd_r ^ sign_flip);
  // ties go to the right run
  assign take_l    = (i_q < mid_q) && ((j_q >= hi_q) || less);
  assign merged    = take_l ? rd_l : rd_r;
  assign out_ext   = EW'(rd_l);

  assign mid_c = ((lo_q + rw_q) > n_ext) ? n_ext : (lo_q + rw_q);
  assign hi_c  = ((lo_q + (rw_q << 1)) > n_ext) ? n_ext : (lo_q + (rw_q << 1));

  assign raddr0_o = i_q[AW-1:0];
  assign raddr1_o = j_q[AW-1:0];

  // load writes A; a merge pass writes the bank that is not the source
  assign a_we_o    = store_key || ((state_q == ST_CMP) && src_q);
  assign a_waddr_o = (state_q == ST_IDLE) ? cnt_q[AW-1:0] : d_q[AW-1:0];
  assign a_wdata_o = (state_q == ST_IDLE) ? key_k : merged;
  assign b_we_o    = (state_q == ST_CMP) && !src_q;
  assign b_waddr_o = d_q[AW-1:0];
  assign b_wdata_o = merged;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    src_d   = src_q;
    rw_d    = rw_q;
    lo_d    = lo_q;
    mid_d   = mid_q;
    hi_d    = hi_q;
    i_d     = i_q;
    j_d     = j_q;
    d_d     = d_q;
    res_d   = res_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (store_key) begin
            cnt_d = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.last) begin
            state_d = ST_PASS;
          end
        end
      end
      ST_PASS: begin
        if (rw_q < n_ext) begin
          lo_d    = '0;
          state_d = ST_SETUP;
        end else begin
          i_d     = '0;
          state_d = ST_EMR;
        end
      end
      ST_SETUP: begin
        if (lo_q >= n_ext) begin
          src_d   = ~src_q;
          rw_d    = rw_q << 1;
          state_d = ST_PASS;
        end else begin
          mid_d   = mid_c;
          hi_d    = hi_c;
          i_d     = lo_q;
          j_d     = mid_c;
          d_d     = lo_q;
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        if (d_q >= hi_q) begin
          lo_d    = lo_q + (rw_q << 1);
          state_d = ST_SETUP;
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (take_l) begin
          i_d = i_q + IW'(1);
        end else begin
          j_d = j_q + IW'(1);
        end
        d_d     = d_q + IW'(1);
        state_d = ST_RD;
      end
      ST_EMR: begin
        state_d = ST_EMO;
      end
      ST_EMO: begin
        res_d.sorted_key = out_ext[31:0];
        res_d.last_out   = ((i_q + IW'(1)) == n_ext);
        res_d.overflow   = ovf_q;
        i_d              = i_q + IW'(1);
        if ((i_q + IW'(1)) == n_ext) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          rw_d    = IW'(MergeMinSize);
          src_d   = 1'b0;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_EMR;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      scmp_q      <= 1'b0;
      src_q       <= 1'b0;
      rw_q        <= IW'(MergeMinSize);
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      src_q       <= src_d;
      rw_q        <= rw_d;
      res_valid_q <= (state_q == ST_EMO);
      if (cfg_we_i) begin
        scmp_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    mid_q <= mid_d;
    hi_q  <= hi_d;
    i_q   <= i_d;
    j_q   <= j_d;
    d_q   <= d_d;
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

@@ hw/rtl/bums_chk.sv @@
// Port-level checker for the merge sorter, bound to the top level.
`include "bottom_up_merge_sort_assert.svh"

module bums_chk import bums_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input in_t  in_i,
  input logic result_valid_o,
  input out_t result_o
);

  // a transfer that closes the set starts the sort at once
  `BUMS_ASSERT_NEXT(a_last_starts_sort, clk_i, rst_ni, start_i && !busy_o && in_i.last, busy_o, "sort did not start after last key")

  // a plain key keeps the input open for the next cycle
  `BUMS_ASSERT_NEXT(a_key_keeps_idle, clk_i, rst_ni, start_i && !busy_o && !in_i.last, !busy_o, "busy after a key without last")

  // results other than the final one only appear while the sort is busy
  `BUMS_ASSERT_NOW(a_mid_result_busy, clk_i, rst_ni, result_valid_o && !result_o.last_out, busy_o, "result strobe while idle")

  // the final result leaves the block idle and is not followed by another
  `BUMS_ASSERT_NOW(a_final_result_idle, clk_i, rst_ni, result_valid_o && result_o.last_out, !busy_o, "busy on final result")

  `BUMS_ASSERT_NEXT(a_final_result_gap, clk_i, rst_ni, result_valid_o && result_o.last_out, !result_valid_o, "result right after final result")

endmodule

bind bottom_up_merge_sort bums_chk u_bums_chk (.*);

@@ tb/bottom_up_merge_sort_tb.sv @@
// Self-checking testbench for the bottom-up merge sorter: directed sets, then random sets.
`timescale 1ns / 1ps

module bottom_up_merge_sort_tb;
  import bums_pkg::*;

  localparam int CycleLimit = 300_000;
  localparam int RandKeys   = 300;
  localparam int PlanRows   = 20;

  typedef struct packed {
    logic [31:0] key;
    logic        last;
    logic        pinned;
    out_t        want;
  } row_t;

  // Single-key sets carry their result inline; everything else goes through the predictor.
  localparam row_t Plan [PlanRows] = '{
    '{32'h0000_0000, 1'b1, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
    '{32'h0000_0005, 1'b0, 1'b0, '0},
    '{32'h0000_0003, 1'b0, 1'b0, '0},
    '{32'h0000_0003, 1'b0, 1'b0, '0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 1'b0, 1'b0, '0},
    '{32'h8000_0000, 1'b0, 1'b0, '0},
    '{32'h7FFF_FFFF, 1'b1, 1'b0, '0},
    '{32'h0000_0002, 1'b0, 1'b0, '0},
    '{32'h0000_0001, 1'b1, 1'b0, '0},
    '{32'h0000_0009, 1'b0, 1'b0, '0},
    '{32'h0000_0009, 1'b0, 1'b0, '0},
    '{32'h0000_0001, 1'b1, 1'b0, '0},
    '{32'h8000_0000, 1'b1, 1'b1, '{32'h8000_0000, 1'b1, 1'b0}},
    '{32'h0000_0010, 1'b0, 1'b0, '0},
    '{32'h0000_0008, 1'b0, 1'b0, '0},
    '{32'h0000_0006, 1'b0, 1'b0, '0},
    '{32'h0000_0004, 1'b0, 1'b0, '0},
    '{32'h0000_0002, 1'b1, 1'b0, '0}
  };

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic start_i     = 1'b0;
  in_t  in_i        = '0;
  logic cfg_we_i    = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic busy_o;
  logic result_valid_o;
  out_t result_o;

  bottom_up_merge_sort dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .in_i          (in_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Sorter model state
  logic [31:0] key_bank [2][MaxElementsDef];
  int unsigned set_len      = 0;
  bit          set_overflow = 1'b0;
  bit          cmp_signed   = 1'b0;
  out_t        sorted_keys_due [$];

  // Inline result for the current directed row
  bit   pin_valid = 1'b0;
  out_t pin_value = '0;

  int errors        = 0;
  int cycles        = 0;
  int keys_taken    = 0;
  int sets_done     = 0;
  int overflow_sets = 0;
  int signed_sets   = 0;
  int keys_checked  = 0;

  function automatic bit key_before(logic [31:0] a, logic [31:0] b);
    if (cmp_signed) return $signed(a) < $signed(b);
    return a < b;
  endfunction

  // Bottom-up merge passes; returns the bank holding the sorted set.
  function automatic bit merge_sort_set();
    int unsigned w, lo, mid, hi, i, j, d;
    bit src;
    src = 1'b0;
    w = 1;
    while (w < set_len) begin
      for (lo = 0; lo < set_len; lo += 2 * w) begin
        mid = (lo + w > set_len) ? set_len : lo + w;
        hi  = (lo + 2 * w > set_len) ? set_len : lo + 2 * w;
        i = lo;
        j = mid;
        for (d = lo; d < hi; d++) begin
          // ties go to the right run
          if (i < mid && (j >= hi || key_before(key_bank[src][i], key_bank[src][j]))) begin
            key_bank[!src][d] = key_bank[src][i];
            i++;
          end else begin
            key_bank[!src][d] = key_bank[src][j];
            j++;
          end
        end
      end
      src = !src;
      w *= 2;
    end
    return src;
  endfunction

  function automatic void take_key(in_t item);
    out_t r;
    bit src;
    int unsigned k;
    keys_taken++;
    if (set_len < MaxElementsDef) begin
      key_bank[0][set_len] = item.key;
      set_len++;
    end else begin
      set_overflow = 1'b1;
    end
    if (!item.last) return;
    src = merge_sort_set();
    for (k = 0; k < set_len; k++) begin
      r.sorted_key = key_bank[src][k];
      r.last_out   = (k == set_len - 1);
      r.overflow   = set_overflow;
      if (pin_valid && set_len == 1) r = pin_value;
      sorted_keys_due.push_back(r);
    end
    sets_done++;
    if (set_overflow) overflow_sets++;
    if (cmp_signed) signed_sets++;
    set_len = 0;
    set_overflow = 1'b0;
  endfunction

  always @(posedge clk_i) begin
    out_t want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst_ni) begin
      if (cfg_we_i) cmp_signed = cfg_wdata_i;
      if (result_valid_o) begin
        if (sorted_keys_due.size() == 0) begin
          $error("unexpected result: sorted_key %h last_out %b overflow %b",
                 result_o.sorted_key, result_o.last_out, result_o.overflow);
          errors++;
        end else begin
          want = sorted_keys_due.pop_front();
          keys_checked++;
          if (result_o.sorted_key !== want.sorted_key) begin
            $error("sorted_key: expected %h, got %h", want.sorted_key, result_o.sorted_key);
            errors++;
          end
          if (result_o.last_out !== want.last_out) begin
            $error("last_out: expected %b, got %b", want.last_out, result_o.last_out);
            errors++;
          end
          if (result_o.overflow !== want.overflow) begin
            $error("overflow: expected %b, got %b", want.overflow, result_o.overflow);
            errors++;
          end
        end
      end
      if (start_i && !busy_o) take_key(in_i);
    end
  end

  // Present one key and hold it until the transfer happens.
  task automatic send_key(logic [31:0] key, logic last, bit pinned, out_t want);
    in_t item;
    item.key  = key;
    item.last = last;
    @(negedge clk_i);
    start_i   <= 1'b1;
    in_i      <= item;
    pin_valid = pinned;
    pin_value = want;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic hold_off(int n);
    in_t noise;
    repeat (n) begin
      noise.key  = $urandom();
      noise.last = 1'($urandom_range(0, 1));
      @(negedge clk_i);
      start_i <= 1'b0;
      in_i    <= noise;
    end
  endtask

  // Stop sending and wait until every sorted key has come out.
  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sorted_keys_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_compare(bit s);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= s;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_key(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 7);
      2: return 32'h7FFF_FFFC + $urandom_range(0, 7);
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          3: return 32'h7FFF_FFFF;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  initial begin
    int sent, size, mode, k;
    bit gaps_on;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table, walked once per compare mode
    for (int pass = 0; pass < 2; pass++) begin
      set_compare(pass[0]);
      foreach (Plan[r]) begin
        if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 6));
        send_key(Plan[r].key, Plan[r].last, Plan[r].pinned, Plan[r].want);
      end
    end
    drain();
    pin_valid = 1'b0;

    sent = 0;
    while (sent < RandKeys) begin
      // no idling toward the end of the run
      gaps_on = (sent < RandKeys - 50);
      if (gaps_on) begin
        if ($urandom_range(0, 5) == 0) set_compare(1'($urandom_range(0, 1)));
        else if ($urandom_range(0, 9) == 0) drain();
      end
      case ($urandom_range(0, 19))
        0: size = MaxElementsDef;
        1: size = MaxElementsDef + 1;
        2: size = $urandom_range(MaxElementsDef + 2, MaxElementsDef + 8);
        default: size = $urandom_range(1, 12);
      endcase
      mode = $urandom_range(0, 3);
      gaps_on = gaps_on && ($urandom_range(0, 2) != 0);
      for (k = 0; k < size; k++) begin
        if (gaps_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 6));
        send_key(pick_key(mode), k == size - 1, 1'b0, '0);
        sent++;
      end
    end

    drain();
    repeat (16) @(posedge clk_i);
    $display("Sorted %0d sets from %0d keys (%0d overflowed, %0d with signed compare);",
             sets_done, keys_taken, overflow_sets, signed_sets);
    $display("%0d sorted keys checked.", keys_checked);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
